// ===== rtl/core/ita_pkg.sv =====
// Package for the integer to ASCII formatter: state codes, radix codes,
// character constants and the digit-to-character function.
// No dependencies.
`default_nettype none

package ita_pkg;

	// Default sizing of the operand and of the field width limit.
	localparam int VALUE_BITS_DEF = 64;
	localparam int MAX_WIDTH_DEF  = 63;

	// Radix codes as they arrive in the request.
	localparam logic [1:0] RADIX_DEC     = 2'd0;
	localparam logic [1:0] RADIX_OCT     = 2'd1;
	localparam logic [1:0] RADIX_HEX     = 2'd2;
	localparam logic [1:0] RADIX_DEC_ALT = 2'd3;

	// ASCII characters used by the formatter.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_LOWER = 8'h61;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_PAD_SP,
		ST_SIGN,
		ST_PAD_ZERO,
		ST_DIGIT
	} ita_state_t;

	// One digit value to its ASCII character.
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
		logic [7:0] ch;
		if (d < 4'd10) begin
			ch = CH_ZERO + {4'b0000, d};
		end else begin
			ch = (up ? CH_UPPER : CH_LOWER) + {4'b0000, d} - 8'd10;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/integer_to_ascii_padded.sv =====
// Top level of the integer to ASCII formatter with padding.
// Depends on ita_pkg for state codes, radix codes and character constants.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: value, min_width; tuser: flags, radix
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: character; tlast: last
//
// A decimal request runs shift-add-3 over all VALUE_BITS bits of the magnitude
// through the shared BCD adjust unit, octal and hex requests skip that step. A
// leading-zero scan then walks the digit register one digit a cycle from the
// top, and one character leaves per cycle while the output register is free.
// Reset clears the sequencer and the output valid. A stalled output holds the
// sequencer in place; a new request is taken as soon as the last character of
// the previous one sits in the output register.
`default_nettype none

module integer_to_ascii_padded
	import ita_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // [63:0] value, [69:64] min_width, rest zero
	input  wire logic [4:0]  s_axis_tuser,  // [0] is_signed, [2:1] radix, [3] upper, [4] zero_fill
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] character
	output logic             m_axis_tlast
);

	localparam int ND = (VALUE_BITS + 2) / 3;
	localparam int PW = $clog2(ND);
	localparam int CW = $clog2(VALUE_BITS + 1);

	ita_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] mag_q;
	logic [ND*4-1:0]       bcd_q;
	logic [CW-1:0]         cnt_q;
	logic [PW-1:0]         ptr_q;
	logic [5:0]            pad_q;
	logic [5:0]            width_q;
	logic                  neg_q;
	logic                  upper_q;
	logic                  zero_q;
	logic                  m_tvalid_q;
	logic [7:0]            m_tdata_q;
	logic                  m_tlast_q;

	// Request fields.
	logic [VALUE_BITS-1:0] val_in;
	logic                  sgn_in;
	logic [1:0]            radix_in;
	logic [5:0]            width_in;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic                  dec_in;
	logic [ND*4-1:0]       mag_ext;
	logic [ND*4-1:0]       grp_dig;

	assign val_in   = s_axis_tdata[VALUE_BITS-1:0];
	assign sgn_in   = s_axis_tuser[0];
	assign radix_in = s_axis_tuser[2:1];
	assign width_in = (s_axis_tdata[69:64] > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : s_axis_tdata[69:64];
	assign neg_in   = sgn_in && val_in[VALUE_BITS-1];
	assign mag_in   = neg_in ? (~val_in + VALUE_BITS'(1)) : val_in;
	assign dec_in   = (radix_in == RADIX_DEC) || (radix_in == RADIX_DEC_ALT);
	assign mag_ext  = {{(ND*4-VALUE_BITS){1'b0}}, mag_in};

	// Octal and hex digits come straight from bit groups of the magnitude.
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (radix_in == RADIX_HEX) begin
				grp_dig[i*4 +: 4] = mag_ext[i*4 +: 4];
			end else begin
				grp_dig[i*4 +: 4] = {1'b0, mag_ext[i*3 +: 3]};
			end
		end
	end

	// Shared BCD adjust unit: add three to every digit of five or more, then shift.
	logic [ND*4-1:0] bcd_adj;
	logic [ND*4-1:0] bcd_shift;

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign bcd_shift = {bcd_adj[ND*4-2:0], mag_q[VALUE_BITS-1]};

	// Digit under the pointer and the padding it leads to.
	logic [3:0] cur_dig;
	logic [6:0] total;
	logic [5:0] pad_calc;
	logic       scan_done;
	logic       out_free;

	assign cur_dig   = bcd_q[{ptr_q, 2'b00} +: 4];
	assign total     = 7'(ptr_q) + 7'd1 + 7'(neg_q);
	assign pad_calc  = ({1'b0, width_q} > total) ? 6'({1'b0, width_q} - total) : 6'd0;
	assign scan_done = (cur_dig != 4'd0) || (ptr_q == '0);
	assign out_free  = !m_tvalid_q || m_axis_tready;

	// Sequencer next state and character selection.
	logic       accept;
	logic       emit;
	logic [7:0] ch_d;
	logic       last_d;

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		emit          = 1'b0;
		ch_d          = CH_SPACE;
		last_d        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = dec_in ? ST_CONV : ST_SCAN;
				end
			end
			ST_CONV: begin
				if (cnt_q == CW'(1)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					if (!zero_q && pad_calc != 6'd0) begin
						state_d = ST_PAD_SP;
					end else if (neg_q) begin
						state_d = ST_SIGN;
					end else if (zero_q && pad_calc != 6'd0) begin
						state_d = ST_PAD_ZERO;
					end else begin
						state_d = ST_DIGIT;
					end
				end
			end
			ST_PAD_SP: begin
				if (out_free) begin
					emit = 1'b1;
					ch_d = CH_SPACE;
					if (pad_q == 6'd1) begin
						state_d = neg_q ? ST_SIGN : ST_DIGIT;
					end
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					emit    = 1'b1;
					ch_d    = CH_MINUS;
					state_d = (zero_q && pad_q != 6'd0) ? ST_PAD_ZERO : ST_DIGIT;
				end
			end
			ST_PAD_ZERO: begin
				if (out_free) begin
					emit = 1'b1;
					ch_d = CH_ZERO;
					if (pad_q == 6'd1) begin
						state_d = ST_DIGIT;
					end
				end
			end
			ST_DIGIT: begin
				if (out_free) begin
					emit   = 1'b1;
					ch_d   = digit_char(cur_dig, upper_q);
					last_d = (ptr_q == '0);
					if (ptr_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	// State register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= ch_d;
			m_tlast_q <= last_d;
		end
	end

	// Operand, digit register, counters and pointer.
	always_ff @(posedge clk) begin
		priority if (accept) begin
			neg_q   <= neg_in;
			upper_q <= s_axis_tuser[3];
			zero_q  <= s_axis_tuser[4];
			width_q <= width_in;
			mag_q   <= mag_in;
			cnt_q   <= CW'(VALUE_BITS);
			ptr_q   <= PW'(ND - 1);
			bcd_q   <= dec_in ? '0 : grp_dig;
		end else if (state_q == ST_CONV) begin
			bcd_q <= bcd_shift;
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
		end else if (state_q == ST_SCAN) begin
			if (scan_done) begin
				pad_q <= pad_calc;
			end else begin
				ptr_q <= ptr_q - PW'(1);
			end
		end else if (emit && (state_q == ST_PAD_SP || state_q == ST_PAD_ZERO)) begin
			pad_q <= pad_q - 6'd1;
		end else if (emit && state_q == ST_DIGIT && ptr_q != '0) begin
			ptr_q <= ptr_q - PW'(1);
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tlast  = m_tlast_q;

`ifndef ASSERT_OFF
	// A taken request keeps the input closed while it is being worked on.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input ready right after a request was taken");

	// Padding states always have at least one pad character left.
	a_pad_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD_SP || state_q == ST_PAD_ZERO) |-> pad_q != 6'd0)
		else $error("padding state entered with empty pad count");

	// The digit pointer stays inside the digit register.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DIGIT) |-> 32'(ptr_q) < ND)
		else $error("digit pointer outside the digit register");

	// Every character sent is printable.
	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata >= CH_SPACE)
		else $error("non-printable character on the output");
`endif

endmodule

`default_nettype wire
